// File: hdl/thuc_pkg.sv
// ----------------------------------------------------------------------------
// thuc_pkg
// Types, constants and the byte-wide CRC-16 update shared by the tape
// header unlock scanner.
// ----------------------------------------------------------------------------
package thuc_pkg;

  localparam logic [7:0]  HdrMark    = 8'h2A;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [4:0]  NameLast   = 5'd11;
  localparam logic [4:0]  OffsetAdd  = 5'd13;
  localparam logic [5:0]  WindowTail = 6'd4;
  localparam logic [15:0] MinLen     = 16'd20;
  localparam logic [1:0]  PrefixLen  = 2'd3;
  localparam logic [4:0]  PosMax     = 5'd31;
  localparam logic [4:0]  UnlockMin  = 5'd14;
  localparam logic [4:0]  UnlockMax  = 5'd24;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] block_length;
    logic        prefix_three;
  } in_word_t;

  typedef struct packed {
    logic        unlock_found;
    logic [4:0]  unlock_position;
    logic        crc_present;
    logic [15:0] header_crc;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  payload_position;
    logic [1:0]  prefix_left;
    logic        header_ok;
    logic        name_ended;
    logic [4:0]  found_offset;
    logic        unlock_bit_set;
    logic [15:0] crc_register;
  } parse_state_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hdl/thuc_parser.sv
// ----------------------------------------------------------------------------
// thuc_parser
// Parse state of one tape block: prefix skip, header mark, name terminator,
// unlock byte and running CRC; forms the result for the last word.
// ----------------------------------------------------------------------------
module thuc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  thuc_pkg::in_word_t  word_i,
  output thuc_pkg::out_word_t result_o
);

  thuc_pkg::parse_state_t state_q, state_d, cur;
  logic       name_hit;
  logic       ended;
  logic [4:0] offset;
  logic [4:0] pos;
  logic [7:0] crc_in;
  logic [15:0] need;
  logic       found;
  logic       crc_ok;

  always_comb begin
    cur = state_q;
    if (word_i.first_byte) begin
      cur = '0;
      cur.prefix_left = word_i.prefix_three ? thuc_pkg::PrefixLen : 2'd0;
    end
    pos      = cur.payload_position;
    state_d  = cur;
    name_hit = 1'b0;
    ended    = cur.name_ended;
    offset   = cur.found_offset;
    crc_in   = word_i.data_byte;
    if (cur.prefix_left != 2'd0) begin
      state_d.prefix_left = cur.prefix_left - 2'd1;
    end else begin
      if (pos == 5'd0) begin
        state_d.header_ok = (word_i.data_byte == thuc_pkg::HdrMark);
      end else begin
        name_hit = cur.header_ok && !cur.name_ended && (pos <= thuc_pkg::NameLast) &&
                   (word_i.data_byte == 8'd0);
        ended    = cur.name_ended || name_hit;
        offset   = name_hit ? (pos + thuc_pkg::OffsetAdd) : cur.found_offset;
        state_d.name_ended   = ended;
        state_d.found_offset = offset;
        if (!ended || ({1'b0, pos} <= ({1'b0, offset} + thuc_pkg::WindowTail))) begin
          if (ended && (pos == offset)) begin
            state_d.unlock_bit_set = word_i.data_byte[0];
            crc_in = {word_i.data_byte[7:1], 1'b0};
          end
          state_d.crc_register = thuc_pkg::crc_byte(cur.crc_register, crc_in);
        end
      end
      if (pos != thuc_pkg::PosMax) begin
        state_d.payload_position = pos + 5'd1;
      end
    end
  end

  always_comb begin
    need   = thuc_pkg::MinLen + (word_i.prefix_three ? 16'd3 : 16'd0);
    found  = state_d.header_ok && state_d.name_ended && (word_i.block_length > need);
    crc_ok = found && state_d.unlock_bit_set &&
             ({1'b0, state_d.payload_position} >
              ({1'b0, state_d.found_offset} + thuc_pkg::WindowTail));
    result_o.unlock_found    = found;
    result_o.unlock_position = found ? state_d.found_offset : 5'd0;
    result_o.crc_present     = crc_ok;
    result_o.header_crc      = crc_ok ? state_d.crc_register : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/tape_header_unlock_crc.sv
// ----------------------------------------------------------------------------
// tape_header_unlock_crc
// Scans the bytes of a tape data block for the header unlock byte and the
// CRC-16 over the header; reports one result word on the last byte.
//
//   channel | signals                         | moves
//   in      | in_valid_i in_ready_o in_data_i | one block byte per word
//   out     | out_valid_o out_ready_i out_data_o | one result per block
//
// One byte per cycle sustained unless a last byte waits on a stalled result;
// the CRC byte update is unrolled between the input register and the result
// register. Reset clears the parse state and both valid flags; no clearing pass.
// A waiting result stalls only a last byte and the input behind it.
// ----------------------------------------------------------------------------
module tape_header_unlock_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  thuc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output thuc_pkg::out_word_t out_data_o
);

  thuc_pkg::in_word_t  s1_q;
  logic                s1_valid_q;
  logic                s1_adv;
  thuc_pkg::out_word_t result;
  thuc_pkg::out_word_t out_q;
  logic                out_valid_q;

  assign s1_adv     = s1_valid_q && (!s1_q.last_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  thuc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .word_i   (s1_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_crc_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_present |-> out_data_o.unlock_found)
    else $error("crc reported without unlock");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.unlock_found |->
      out_data_o.unlock_position == 5'd0 && out_data_o.header_crc == 16'd0)
    else $error("fields not cleared when not found");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unlock_found |->
      out_data_o.unlock_position >= thuc_pkg::UnlockMin &&
      out_data_o.unlock_position <= thuc_pkg::UnlockMax)
    else $error("unlock position out of range");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.last_byte && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("last byte dropped while result stalled");
`endif

endmodule

// File: dv/tape_header_unlock_crc_tb.sv
// ----------------------------------------------------------------------------
// tape_header_unlock_crc_tb
// Streams tape blocks through the unlock scanner and checks each result word
// against a cycle-free scan of the same bytes: header mark, name terminator,
// unlock offset and the CRC-16 over the header window. Blocks are mostly
// well formed with random content, mixed with short, truncated, long,
// unmarked and noise blocks, under random idling on both channels.
// ----------------------------------------------------------------------------
module tape_header_unlock_crc_tb;

  typedef logic [7:0] octet_q_t[$];

  localparam int QuietLimit = 1000;
  localparam int RandomWords = 1800;
  localparam int CalmWords = 150;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  thuc_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  thuc_pkg::out_word_t out_data_o;

  thuc_pkg::in_word_t  byte_words_q[$];
  thuc_pkg::out_word_t unlock_reports_q[$];
  int        reports_planned = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        in_bursty = 1'b1;
  bit        out_bursty = 1'b1;

  logic [4:0]  scan_pos = '0;
  logic [1:0]  skip_left = '0;
  logic        mark_ok = 1'b0;
  logic        name_done = 1'b0;
  logic [4:0]  unlock_at = '0;
  logic        unlock_bit = 1'b0;
  logic [15:0] crc_acc = '0;

  thuc_pkg::out_word_t predicted;
  thuc_pkg::out_word_t wanted;

  tape_header_unlock_crc dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc_shift(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? thuc_pkg::CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit scan_tape_byte(input thuc_pkg::in_word_t w,
                                        output thuc_pkg::out_word_t res);
    logic [7:0]  d;
    logic [15:0] need;
    logic        hit;
    logic        crc_ok;
    res = '0;
    if (w.first_byte) begin
      scan_pos = '0;
      mark_ok = 1'b0;
      name_done = 1'b0;
      unlock_at = '0;
      unlock_bit = 1'b0;
      crc_acc = '0;
      skip_left = w.prefix_three ? thuc_pkg::PrefixLen : 2'd0;
    end
    if (skip_left != 2'd0) begin
      skip_left = skip_left - 2'd1;
    end else begin
      if (scan_pos == 5'd0) begin
        mark_ok = (w.data_byte == thuc_pkg::HdrMark);
      end else begin
        if (mark_ok && !name_done && scan_pos <= thuc_pkg::NameLast &&
            w.data_byte == 8'h00) begin
          name_done = 1'b1;
          unlock_at = scan_pos + thuc_pkg::OffsetAdd;
        end
        if (!name_done ||
            {1'b0, scan_pos} <= {1'b0, unlock_at} + thuc_pkg::WindowTail) begin
          d = w.data_byte;
          if (name_done && scan_pos == unlock_at) begin
            unlock_bit = d[0];
            d[0] = 1'b0;
          end
          crc_acc = crc_shift(crc_acc, d);
        end
      end
      if (scan_pos != thuc_pkg::PosMax) scan_pos = scan_pos + 5'd1;
    end
    if (!w.last_byte) return 1'b0;
    need = thuc_pkg::MinLen + (w.prefix_three ? 16'd3 : 16'd0);
    hit = mark_ok && name_done && (w.block_length > need);
    crc_ok = hit && unlock_bit &&
             ({1'b0, scan_pos} > {1'b0, unlock_at} + thuc_pkg::WindowTail);
    res.unlock_found = hit;
    res.unlock_position = hit ? unlock_at : 5'd0;
    res.crc_present = crc_ok;
    res.header_crc = crc_ok ? crc_acc : 16'h0000;
    return 1'b1;
  endfunction

  task automatic add_block(input octet_q_t bytes, input bit pfx, input logic [15:0] blen,
                           input bit mark_first, input bit mark_last);
    thuc_pkg::in_word_t w;
    for (int i = 0; i < bytes.size(); i++) begin
      w.data_byte = bytes[i];
      w.first_byte = mark_first && (i == 0);
      w.last_byte = mark_last && (i == bytes.size() - 1);
      w.block_length = blen;
      w.prefix_three = pfx;
      byte_words_q.push_back(w);
    end
    if (mark_last && bytes.size() != 0) reports_planned++;
  endtask

  task automatic queue_random_block();
    octet_q_t    bytes;
    int          roll;
    int          name_end;
    int          unlock_pos;
    int          pay_len;
    int          pick;
    bit          pfx;
    logic [7:0]  b;
    logic [15:0] blen;
    bytes = {};
    pfx = 1'($urandom_range(0, 1));
    if (pfx) repeat (3) bytes.push_back(8'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      name_end = $urandom_range(1, 11);
      if (roll < 55) pay_len = $urandom_range(name_end + 18, name_end + 25);
      else if (roll < 65) pay_len = $urandom_range(name_end + 1, name_end + 17);
      else if (roll < 72) pay_len = $urandom_range(32, 60);
      else begin
        name_end = 0;
        pay_len = $urandom_range(20, 35);
      end
      unlock_pos = name_end + 13;
      bytes.push_back(($urandom_range(0, 9) != 0) ? thuc_pkg::HdrMark : 8'($urandom));
      for (int i = 1; i < pay_len; i++) begin
        if (i == name_end) b = 8'h00;
        else if (i < name_end || (name_end == 0 && i <= 11)) b = 8'($urandom_range(1, 255));
        else if (name_end != 0 && i == unlock_pos) begin
          b = 8'($urandom);
          b[0] = ($urandom_range(0, 3) != 0);
        end else b = 8'($urandom);
        bytes.push_back(b);
      end
    end else begin
      pay_len = $urandom_range(1, 40);
      for (int i = 0; i < pay_len; i++) begin
        b = 8'($urandom);
        if (i == 0 && $urandom_range(0, 1)) b = thuc_pkg::HdrMark;
        bytes.push_back(b);
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) blen = 16'(bytes.size());
    else if (pick == 7) blen = 16'($urandom);
    else blen = 16'($urandom_range(18, 26));
    add_block(bytes, pfx, blen, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
  endtask

  task automatic report_mismatch(input string what, input thuc_pkg::out_word_t exp_w,
                                 input thuc_pkg::out_word_t act_w);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%0t %s: expected found=%0d pos=%0d crc_ok=%0d crc=%h, ",
             $time, what, exp_w.unlock_found, exp_w.unlock_position, exp_w.crc_present,
             exp_w.header_crc);
      $display("got found=%0d pos=%0d crc_ok=%0d crc=%h",
               act_w.unlock_found, act_w.unlock_position, act_w.crc_present,
               act_w.header_crc);
    end
  endtask

  always @(posedge clk_i) begin
    in_bursty <= ($urandom_range(0, 63) == 0) ? ~in_bursty : in_bursty;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (byte_words_q.size() > CalmWords && in_bursty && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        in_gap <= $urandom_range(0, 7);
      end else if (byte_words_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= byte_words_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_bursty <= ($urandom_range(0, 63) == 0) ? ~out_bursty : out_bursty;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      out_ready_i <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (byte_words_q.size() > CalmWords && out_bursty && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      out_gap <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (scan_tape_byte(in_data_i, predicted)) unlock_reports_q.push_back(predicted);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (unlock_reports_q.size() == 0) begin
        report_mismatch("unexpected word", '0, out_data_o);
      end else begin
        wanted = unlock_reports_q.pop_front();
        if (out_data_o.unlock_found !== wanted.unlock_found ||
            out_data_o.unlock_position !== wanted.unlock_position ||
            out_data_o.crc_present !== wanted.crc_present ||
            out_data_o.header_crc !== wanted.header_crc) begin
          report_mismatch("mismatch", wanted, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    octet_q_t            bytes;
    int                  directed_words;
    thuc_pkg::out_word_t leftover;
    bytes = '{8'hFF};
    add_block(bytes, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    bytes = '{8'h00};
    add_block(bytes, 1'b0, 16'h0000, 1'b1, 1'b1);
    bytes = '{thuc_pkg::HdrMark};
    add_block(bytes, 1'b0, 16'd21, 1'b0, 1'b0);
    bytes = '{thuc_pkg::HdrMark, 8'h00};
    repeat (12) bytes.push_back(8'h55);
    bytes.push_back(8'h81);
    bytes.push_back(8'hFF);
    bytes.push_back(8'h00);
    bytes.push_back(8'hAA);
    bytes.push_back(8'h5A);
    bytes.push_back(8'h80);
    bytes.push_back(8'h7F);
    add_block(bytes, 1'b0, 16'd21, 1'b1, 1'b1);
    directed_words = byte_words_q.size();
    while (byte_words_q.size() < directed_words + RandomWords || reports_planned < 40)
      queue_random_block();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_words_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (unlock_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (unlock_reports_q.size() != 0) begin
      leftover = unlock_reports_q.pop_front();
      report_mismatch("missing word", leftover, '0);
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/thuc_pkg.sv
hdl/thuc_parser.sv
hdl/tape_header_unlock_crc.sv
dv/tape_header_unlock_crc_tb.sv
